FILE: hw/rtl/dnsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnsc_pkg
// Shared types, constants and helpers for the domain name syntax checker.
// ----------------------------------------------------------------------------
package dnsc_pkg;

  localparam int unsigned PrefixLen = 8;
  localparam int unsigned PosW      = $clog2(PrefixLen);

  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChSlash     = 8'h2f;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChThree     = 8'h33;
  localparam logic [7:0] ChSeven     = 8'h37;
  localparam logic [7:0] ChDel       = 8'd127;
  localparam logic [7:0] OctMaxLow   = 8'd32;

  typedef enum logic [2:0] {
    PH_PREFIX       = 3'd0,
    PH_AFTER_PREFIX = 3'd1,
    PH_EXPECT_SLASH = 3'd2,
    PH_SEGMENT      = 3'd3,
    PH_ESC1         = 3'd4,
    PH_ESC2         = 3'd5,
    PH_ESC3         = 3'd6,
    PH_ERROR        = 3'd7
  } phase_e;

  // One word handed from the input register to the parser.
  typedef struct packed {
    logic       take;
    logic       last;
    logic [7:0] ch;
  } dnsc_step_t;

  // Literal "<kernel>", one character per position.
  function automatic logic [7:0] prefix_char(input logic [PosW-1:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h3c;
      3'd1:    c = 8'h6b;
      3'd2:    c = 8'h65;
      3'd3:    c = 8'h72;
      3'd4:    c = 8'h6e;
      3'd5:    c = 8'h65;
      3'd6:    c = 8'h6c;
      3'd7:    c = 8'h3e;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_octal(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChSeven);
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/domain_name_syntax_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// domain_name_syntax_checker
// Streams a domain name byte by byte and returns one verdict per name.
// ----------------------------------------------------------------------------
// Feed one name byte per word on s_axis_tdata; a word with s_axis_tlast high
// carries no byte and closes the name. The block takes one word per cycle
// and returns, for each closing word, one word whose bit 0 is 1 if the name
// was "<kernel>" followed by well-formed " /" segments. A word passes an
// input register and the parse state machine, and the verdict leaves from
// an output register. Input stalls only when a verdict waits behind a
// stalled output.
module domain_name_syntax_checker (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire  [7:0] s_axis_tdata,   // [7:0] char_byte
  input  wire        s_axis_tlast,   // end_of_name
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] name_valid, [7:1] zero
);

  logic                 in_vld_q, in_vld_d;
  logic [7:0]           in_ch_q;
  logic                 in_last_q;
  logic                 out_vld_q, out_vld_d;
  logic                 out_res_q;
  logic                 advance;
  logic                 s_fire;
  logic                 verdict;
  dnsc_pkg::dnsc_step_t step;

  // a plain byte never needs the output; a closing word needs a free slot
  assign advance = in_vld_q && (!in_last_q || !out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign s_fire = s_axis_tvalid && s_axis_tready;

  assign step.take = advance;
  assign step.last = in_last_q;
  assign step.ch   = in_ch_q;

  dnsc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .name_valid_o(verdict)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_fire) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance && in_last_q) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_ch_q   <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (advance && in_last_q) begin
      out_res_q <= verdict;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'b0000000, out_res_q};

endmodule
`default_nettype wire

FILE: hw/rtl/dnsc_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnsc_parser
// Parse state machine: advances one byte per step and reports the verdict
// of the name parsed so far.
// ----------------------------------------------------------------------------
module dnsc_parser (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  dnsc_pkg::dnsc_step_t step_i,
  output logic                name_valid_o
);

  dnsc_pkg::phase_e            phase_q, phase_d;
  logic [dnsc_pkg::PosW-1:0]   pos_q, pos_d;
  logic [4:0]                  oct_q, oct_d;
  logic [7:0]                  ch;
  logic [2:0]                  digit;
  logic [7:0]                  esc_val;

  assign ch      = step_i.ch;
  assign digit   = ch[2:0];
  assign esc_val = {oct_q, digit};

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    oct_d   = oct_q;
    if (step_i.take && step_i.last) begin
      phase_d = dnsc_pkg::PH_PREFIX;
      pos_d   = '0;
      oct_d   = '0;
    end else if (step_i.take) begin
      unique case (phase_q)
        dnsc_pkg::PH_PREFIX: begin
          if (ch == dnsc_pkg::prefix_char(pos_q)) begin
            // wraps to zero exactly when the whole prefix has matched
            pos_d = pos_q + 1'b1;
            if (pos_q == dnsc_pkg::PosW'(dnsc_pkg::PrefixLen - 1)) begin
              phase_d = dnsc_pkg::PH_AFTER_PREFIX;
            end
          end else begin
            phase_d = dnsc_pkg::PH_ERROR;
          end
        end
        dnsc_pkg::PH_AFTER_PREFIX: begin
          phase_d = (ch == dnsc_pkg::ChSpace) ? dnsc_pkg::PH_EXPECT_SLASH
                                              : dnsc_pkg::PH_ERROR;
        end
        dnsc_pkg::PH_EXPECT_SLASH: begin
          phase_d = (ch == dnsc_pkg::ChSlash) ? dnsc_pkg::PH_SEGMENT
                                              : dnsc_pkg::PH_ERROR;
        end
        dnsc_pkg::PH_SEGMENT: begin
          priority if (ch == dnsc_pkg::ChSpace) begin
            phase_d = dnsc_pkg::PH_EXPECT_SLASH;
          end else if (ch == dnsc_pkg::ChBackslash) begin
            phase_d = dnsc_pkg::PH_ESC1;
          end else if (ch < dnsc_pkg::ChSpace || ch >= dnsc_pkg::ChDel) begin
            phase_d = dnsc_pkg::PH_ERROR;
          end
        end
        dnsc_pkg::PH_ESC1: begin
          priority if (ch == dnsc_pkg::ChBackslash) begin
            phase_d = dnsc_pkg::PH_SEGMENT;
          end else if (ch >= dnsc_pkg::ChZero && ch <= dnsc_pkg::ChThree) begin
            oct_d   = {3'b000, ch[1:0]};
            phase_d = dnsc_pkg::PH_ESC2;
          end else begin
            phase_d = dnsc_pkg::PH_ERROR;
          end
        end
        dnsc_pkg::PH_ESC2: begin
          if (dnsc_pkg::is_octal(ch)) begin
            oct_d   = {oct_q[1:0], digit};
            phase_d = dnsc_pkg::PH_ESC3;
          end else begin
            phase_d = dnsc_pkg::PH_ERROR;
          end
        end
        dnsc_pkg::PH_ESC3: begin
          if (dnsc_pkg::is_octal(ch) && esc_val != 8'd0 &&
              (esc_val <= dnsc_pkg::OctMaxLow || esc_val >= dnsc_pkg::ChDel)) begin
            phase_d = dnsc_pkg::PH_SEGMENT;
          end else begin
            phase_d = dnsc_pkg::PH_ERROR;
          end
        end
        default: begin
          phase_d = dnsc_pkg::PH_ERROR;
        end
      endcase
    end
  end

  always_comb begin
    name_valid_o = (phase_q == dnsc_pkg::PH_AFTER_PREFIX) ||
                   (phase_q == dnsc_pkg::PH_SEGMENT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dnsc_pkg::PH_PREFIX;
      pos_q   <= '0;
      oct_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      oct_q   <= oct_d;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/dnsc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnsc_checker
// Port-level checks for the domain name syntax checker, bound to the top.
// ----------------------------------------------------------------------------
module dnsc_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       s_axis_tvalid,
  input wire       s_axis_tready,
  input wire       s_axis_tlast,
  input wire       m_axis_tvalid,
  input wire       m_axis_tready,
  input wire [7:0] m_axis_tdata
);

  logic [1:0] pend_q, pend_d;
  logic       end_in;
  logic       res_out;

  assign end_in  = s_axis_tvalid && s_axis_tready && s_axis_tlast;
  assign res_out = m_axis_tvalid && m_axis_tready;

  // count closing words taken but not yet answered
  always_comb begin
    pend_d = pend_q;
    if (end_in && !res_out) begin
      pend_d = pend_q + 2'd1;
    end else if (!end_in && res_out) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("verdict dropped or changed while stalled");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
    else $error("verdict padding not zero");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a blocked verdict");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 2'd0)
    else $error("verdict without a closing word");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("too many unanswered names");

endmodule

bind domain_name_syntax_checker dnsc_checker u_dnsc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tlast (s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
`default_nettype wire

FILE: bench/dnsc_verdict_tracker.sv
// ----------------------------------------------------------------------------
// dnsc_verdict_tracker
// Watches both stream channels of the domain name syntax checker, parses each
// accepted name itself and compares every verdict word with its own outcome.
// ----------------------------------------------------------------------------
module dnsc_verdict_tracker
  import dnsc_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        s_tvalid_i,
  input  wire        s_tready_i,
  input  wire  [7:0] s_tdata_i,
  input  wire        s_tlast_i,
  input  wire        m_tvalid_i,
  input  wire        m_tready_i,
  input  wire  [7:0] m_tdata_i,
  output int         mismatches_o,
  output int         judged_o,
  output int         accepted_o,
  output int         pending_o
);

  typedef struct packed {
    phase_e     phase;
    logic [3:0] prefix_pos;
    logic [4:0] oct_acc;
  } parse_state_t;

  localparam parse_state_t ParseIdle = '{phase: PH_PREFIX, prefix_pos: 4'd0, oct_acc: 5'd0};
  localparam logic [63:0]  KernelTag = "<kernel>";

  parse_state_t name_state;
  logic         name_verdicts[$];
  int           verdicts_seen;

  function automatic parse_state_t next_parse_state(parse_state_t st, logic [7:0] c);
    parse_state_t nx;
    logic [7:0]   tag_ch;
    logic [7:0]   code;
    nx     = st;
    tag_ch = KernelTag[8 * (7 - st.prefix_pos[2:0]) +: 8];
    code   = {st.oct_acc, c[2:0]};
    case (st.phase)
      PH_PREFIX: begin
        if (st.prefix_pos < PrefixLen && c == tag_ch) begin
          nx.prefix_pos = st.prefix_pos + 4'd1;
          if (nx.prefix_pos == PrefixLen) nx.phase = PH_AFTER_PREFIX;
        end else begin
          nx.phase = PH_ERROR;
        end
      end
      PH_AFTER_PREFIX: nx.phase = (c == ChSpace) ? PH_EXPECT_SLASH : PH_ERROR;
      PH_EXPECT_SLASH: nx.phase = (c == ChSlash) ? PH_SEGMENT : PH_ERROR;
      PH_SEGMENT: begin
        if (c == ChSpace) nx.phase = PH_EXPECT_SLASH;
        else if (c == ChBackslash) nx.phase = PH_ESC1;
        else if (c < ChSpace || c >= ChDel) nx.phase = PH_ERROR;
      end
      PH_ESC1: begin
        if (c == ChBackslash) begin
          nx.phase = PH_SEGMENT;
        end else if (c >= ChZero && c <= ChThree) begin
          nx.oct_acc = {3'd0, c[1:0]};
          nx.phase   = PH_ESC2;
        end else begin
          nx.phase = PH_ERROR;
        end
      end
      PH_ESC2: begin
        if (c >= ChZero && c <= ChSeven) begin
          nx.oct_acc = {st.oct_acc[1:0], c[2:0]};
          nx.phase   = PH_ESC3;
        end else begin
          nx.phase = PH_ERROR;
        end
      end
      PH_ESC3: begin
        // escaped code must be nonzero and either at most ChSpace or at least ChDel
        if (c >= ChZero && c <= ChSeven && code != 8'd0 && (code <= ChSpace || code >= ChDel))
          nx.phase = PH_SEGMENT;
        else
          nx.phase = PH_ERROR;
      end
      default: nx.phase = PH_ERROR;
    endcase
    return nx;
  endfunction

  assign pending_o = judged_o - verdicts_seen;

  always @(posedge clk_i or negedge rst_ni) begin : track
    int   errs;
    logic want;
    if (!rst_ni) begin
      name_state = ParseIdle;
      name_verdicts.delete();
      mismatches_o  <= 0;
      judged_o      <= 0;
      accepted_o    <= 0;
      verdicts_seen <= 0;
    end else begin
      errs = 0;
      // retire the output word first so a same-cycle closing word cannot pair with it
      if (m_tvalid_i && m_tready_i) begin
        verdicts_seen <= verdicts_seen + 1;
        if (name_verdicts.size() == 0) begin
          $error("verdict word %h with no name waiting", m_tdata_i);
          errs++;
        end else begin
          want = name_verdicts.pop_front();
          if (m_tdata_i[0] !== want) begin
            $error("name_valid: expected %0d, got %0d", want, m_tdata_i[0]);
            errs++;
          end
          if (m_tdata_i[7:1] !== 7'd0) begin
            $error("tdata padding: expected %h, got %h", 7'd0, m_tdata_i[7:1]);
            errs++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        if (s_tlast_i) begin
          want = (name_state.phase == PH_AFTER_PREFIX || name_state.phase == PH_SEGMENT);
          name_verdicts.push_back(want);
          judged_o   <= judged_o + 1;
          accepted_o <= accepted_o + int'(want);
          name_state = ParseIdle;
        end else begin
          name_state = next_parse_state(name_state, s_tdata_i);
        end
      end
      mismatches_o <= mismatches_o + errs;
    end
  end

endmodule

FILE: bench/domain_name_syntax_checker_test.sv
// ----------------------------------------------------------------------------
// domain_name_syntax_checker_test
// Feeds directed and random domain names, well formed and broken, through the
// checker under random idling and back-pressure; verdicts are compared by a
// tracker module that parses every name on its own.
// ----------------------------------------------------------------------------
module domain_name_syntax_checker_test;
  import dnsc_pkg::*;

  localparam int WordTarget = 1400;
  localparam int StuckLimit = 3000;
  localparam int HoldCycles = 400;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       s_tvalid;
  logic [7:0] s_tdata;
  logic       s_tlast;
  wire        s_tready;
  wire        m_tvalid;
  logic       m_tready;
  wire  [7:0] m_tdata;

  int         mismatches;
  int         judged;
  int         accepted;
  int         pending;

  logic       quiet;
  logic       hold_go;
  bit         hold_done;
  bit         burst_mode;
  int         words_in;
  int         stuck_cycles;
  logic [7:0] name_q[$];

  always #5 clk_i = ~clk_i;

  domain_name_syntax_checker u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  dnsc_verdict_tracker u_tracker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tlast_i    (s_tlast),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .mismatches_o (mismatches),
    .judged_o     (judged),
    .accepted_o   (accepted),
    .pending_o    (pending)
  );

  task automatic put_word(input logic [7:0] b, input logic closing);
    if (!quiet && !burst_mode && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= closing;
    do @(posedge clk_i); while (!s_tready);
    words_in++;
  endtask

  task automatic append_text(input string s);
    for (int i = 0; i < s.len(); i++) name_q.push_back(s[i]);
  endtask

  // send the collected bytes, then a closing word with a junk byte
  task automatic send_name();
    foreach (name_q[i]) put_word(name_q[i], 1'b0);
    put_word(8'($urandom), 1'b1);
    name_q.delete();
  endtask

  // mostly an octal digit up to 'top', now and then a decimal one
  function automatic logic [7:0] rand_digit(input int top);
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(8'h30, 8'h39));
    return ChZero + 8'($urandom_range(0, top));
  endfunction

  task automatic make_random_name();
    int keep;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(0, 10)) name_q.push_back(8'($urandom));
    end else begin
      append_text("<kernel>");
      if ($urandom_range(0, 11) == 0) name_q[$urandom_range(0, 7)] = 8'($urandom);
      repeat ($urandom_range(0, 3)) begin
        append_text(" /");
        repeat ($urandom_range(0, 5)) begin
          case ($urandom_range(0, 19))
            13, 14: append_text("\\\\");
            15, 16, 17: begin
              name_q.push_back(ChBackslash);
              name_q.push_back(rand_digit(3));
              name_q.push_back(rand_digit(7));
              name_q.push_back(rand_digit(7));
            end
            18: name_q.push_back(8'($urandom));
            19: name_q.push_back(ChBackslash);
            default: name_q.push_back(8'($urandom_range(33, 126)));
          endcase
        end
      end
      if ($urandom_range(0, 11) == 0) name_q.push_back(ChSpace);
      if ($urandom_range(0, 11) == 0) begin
        keep = $urandom_range(0, name_q.size());
        while (name_q.size() > keep) void'(name_q.pop_back());
      end
    end
  endtask

  // receiver: random stalls, one long hold-off, none in the quiet tail
  initial begin
    m_tready <= 1'b0;
    hold_done = 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_go && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= StuckLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    bit paused;
    rst_ni       <= 1'b0;
    s_tvalid     <= 1'b0;
    s_tdata      <= 8'd0;
    s_tlast      <= 1'b0;
    quiet        <= 1'b0;
    hold_go      <= 1'b0;
    burst_mode = 1'b0;
    paused     = 1'b0;
    words_in   = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed names: prefix, segments, escapes and the early-end cases
    send_name();
    append_text("<kern");        send_name();
    append_text("<Kernel>");     send_name();
    append_text("<kernel>");     send_name();
    append_text("<kernel>x");    send_name();
    append_text("<kernel> ");    send_name();
    append_text("<kernel>  /");  send_name();
    append_text("<kernel> a");   send_name();
    append_text("<kernel> /");   send_name();
    append_text("<kernel> /ab~! /x /");  send_name();
    append_text("<kernel> /a\\\\b");     send_name();
    append_text("<kernel> /\\001");      send_name();
    append_text("<kernel> /\\040");      send_name();
    append_text("<kernel> /\\041");      send_name();
    append_text("<kernel> /\\176");      send_name();
    append_text("<kernel> /\\177");      send_name();
    append_text("<kernel> /\\377");      send_name();
    append_text("<kernel> /\\000");      send_name();
    append_text("<kernel> /\\400");      send_name();
    append_text("<kernel> /\\18x");      send_name();
    append_text("<kernel> /\\12");       send_name();
    append_text("<kernel> /\\");         send_name();
    append_text("<kernel> /a"); name_q.push_back(8'h00); send_name();
    append_text("<kernel> /a"); name_q.push_back(8'h1f); send_name();
    append_text("<kernel> /a"); name_q.push_back(8'hff); append_text("b"); send_name();

    while (words_in < WordTarget) begin
      if (!hold_go && words_in >= 450) begin
        // flood short names while the receiver holds off
        hold_go    <= 1'b1;
        burst_mode = 1'b1;
        repeat (40) begin
          if ($urandom_range(0, 3) == 0) append_text("<kernel>");
          send_name();
        end
        burst_mode = 1'b0;
      end else if (!paused && words_in >= 800) begin
        paused = 1'b1;
        s_tvalid <= 1'b0;
        do @(posedge clk_i); while (pending != 0);
      end else begin
        if (words_in >= 1150) quiet <= 1'b1;
        make_random_name();
        send_name();
      end
    end

    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    $display("Summary: %0d words sent, %0d names judged (%0d valid, %0d invalid)",
             words_in, judged, accepted, judged - accepted);
    $display("Summary: escapes, bad bytes, truncated names and a long output stall covered");
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
